>>> sv/sha_pkg.sv
// Shared constants, types and functions of the SHA-256 stream hasher.
package sha_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;
    localparam int unsigned LenBytePos = 56;
    localparam logic [7:0]  PadByte    = 8'h80;

    typedef logic [31:0] t_word;

    function automatic t_word round_const(input logic [5:0] t);
        t_word k;
        case (t)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word init_hash(input logic [2:0] i);
        t_word h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    // Handshake between the byte front end and the round engine.
    typedef struct packed {
        logic start;
        logic last;   // final block of a message: emit the digest after it
    } t_blk_req;

endpackage

>>> sv/sha_if.sv
// Valid/ready channel interfaces of the SHA-256 stream hasher.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> sv/sha_engine.sv
// SHA-256 round engine: message schedule memory, 64 rounds, chaining update.
module sha_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha_pkg::t_blk_req    i_req,
    output logic                 o_busy,
    // block word read port into the front end's buffer
    output logic [3:0]           o_blk_addr,
    input  sha_pkg::t_word       i_blk_word,
    // digest words out
    output logic                 o_valid,
    input  logic                 i_ready,
    output sha_pkg::t_word       o_word,
    output logic [2:0]           o_index
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PRIME = 6'b000010,
        S_ROUND = 6'b000100,
        S_ADD   = 6'b001000,
        S_EMIT  = 6'b010000,
        S_INIT  = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    sha_pkg::t_word r_v [8];
    sha_pkg::t_word r_h [8];
    sha_pkg::t_word r_w [16];   // sliding 16-word schedule window
    logic [6:0]    r_t;
    logic          r_last;
    logic [2:0]    r_idx;

    sha_pkg::t_word w_cur, sig1, pick, t1, sig0, vote, t2, s0, s1, w_new, x, y;
    logic [5:0]    t6;

    assign t6 = r_t[5:0];
    assign x  = r_w[1];
    assign y  = r_w[14];
    assign s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    assign s1 = {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ (y >> 10);
    assign w_new = s1 + r_w[9] + s0 + r_w[0];
    // first 16 rounds take words straight from the buffer memory
    assign w_cur = (r_t < 7'd16) ? i_blk_word : w_new;

    assign sig1 = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
                ^ {r_v[4][24:0], r_v[4][31:25]};
    assign pick = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign t1   = r_v[7] + sig1 + pick + sha_pkg::round_const(t6) + w_cur;
    assign sig0 = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
                ^ {r_v[0][21:0], r_v[0][31:22]};
    assign vote = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t2   = sig0 + vote;

    // buffer memory read is registered: address runs one round ahead
    always_comb begin
        o_blk_addr = 4'd0;
        if (r_state == S_ROUND) begin
            o_blk_addr = 4'(r_t + 7'd1);
        end
    end

    assign o_busy  = (r_state != S_IDLE) || i_req.start;
    assign o_valid = (r_state == S_EMIT);
    assign o_word  = r_h[r_idx];
    assign o_index = r_idx;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_req.start) n_state = S_PRIME;
            S_PRIME: n_state = S_ROUND;
            S_ROUND: if (r_t == 7'(sha_pkg::Rounds - 1)) n_state = S_ADD;
            S_ADD:   n_state = r_last ? S_EMIT : S_IDLE;
            S_EMIT:  if (i_ready && r_idx == 3'd7) n_state = S_INIT;
            S_INIT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_idx   <= 3'd0;
            r_t     <= 7'd0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_last <= i_req.last;
                    r_t    <= 7'd0;
                end
                S_PRIME: begin
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                end
                S_ROUND: begin
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_cur;
                    r_t <= r_t + 7'd1;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_idx <= 3'd0;
                end
                S_EMIT: begin
                    if (i_ready) r_idx <= r_idx + 3'd1;
                end
                S_INIT: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::init_hash(3'(i));
                end
                default: ;
            endcase
        end
    end
endmodule

>>> sv/sha_front.sv
// Byte front end: block buffer memory, fill count, bit count and padding.
module sha_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sha_in_if.sink            in_ch,
    output sha_pkg::t_blk_req o_req,
    input  logic              i_eng_busy,
    input  logic              i_eng_done,   // digest fully delivered
    input  logic [3:0]        i_rd_addr,
    output sha_pkg::t_word    o_rd_word
);
    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_PAD  = 4'b0010,
        F_WAIT = 4'b0100,
        F_DONE = 4'b1000
    } t_fstate;

    t_fstate     r_state;
    logic [5:0]  r_fill;
    logic [63:0] r_len;
    logic        r_full;      // a full block waits on a busy engine
    logic        r_padlast;   // current padding block carries the length
    logic        r_end;       // end seen, padding still to run
    sha_pkg::t_word r_mem [16];  // 64 bytes held as 16 big-endian words

    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_byte;
    logic        take;
    logic [7:0]  len_byte;

    // block memory, byte-lane writes, registered word read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            case (wr_addr[1:0])
                2'd0:    r_mem[wr_addr[5:2]][31:24] <= wr_byte;
                2'd1:    r_mem[wr_addr[5:2]][23:16] <= wr_byte;
                2'd2:    r_mem[wr_addr[5:2]][15:8]  <= wr_byte;
                default: r_mem[wr_addr[5:2]][7:0]   <= wr_byte;
            endcase
        end
        o_rd_word <= r_mem[i_rd_addr];
    end

    // no writes while the engine reads the buffer
    assign in_ch.ready = (r_state == F_IDLE) && !r_full && !r_end && !i_eng_busy;
    assign take = in_ch.valid && in_ch.ready;
    assign len_byte = r_len[8*(7 - r_fill[2:0]) +: 8];

    always_comb begin
        wr_en = 1'b0; wr_addr = r_fill; wr_byte = in_ch.data_byte;
        if (take && in_ch.byte_present) begin
            wr_en = 1'b1;
        end else if (r_state == F_PAD && !r_full && !i_eng_busy) begin
            wr_en = 1'b1;
            if (r_fill >= 6'(sha_pkg::LenBytePos) && r_padlast) wr_byte = len_byte;
            else wr_byte = 8'h00;
        end else if (r_end && r_state == F_IDLE && !r_full && !i_eng_busy) begin
            wr_en = 1'b1;
            wr_byte = sha_pkg::PadByte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE; r_fill <= 6'd0; r_len <= 64'd0;
            r_full <= 1'b0; r_padlast <= 1'b0; r_end <= 1'b0;
            o_req <= '0;
        end else begin
            // a full block is handed over once the engine is free
            if (r_full && !i_eng_busy) begin
                r_full <= 1'b0;
                o_req.start <= 1'b1;
                o_req.last  <= (r_state == F_PAD) && r_padlast;
                if (r_state == F_PAD && r_padlast) r_state <= F_WAIT;
            end else begin
                o_req <= '0;
            end
            case (r_state)
                F_IDLE: begin
                    if (take) begin
                        if (in_ch.byte_present) begin
                            r_fill <= r_fill + 6'd1;
                            r_len  <= r_len + 64'd8;
                            if (r_fill == 6'd63) r_full <= 1'b1;
                        end
                        r_end <= in_ch.end_of_message;
                    end else if (r_end && !r_full && !i_eng_busy) begin
                        // place the 0x80 marker, then fill
                        r_end     <= 1'b0;
                        r_fill    <= r_fill + 6'd1;
                        r_padlast <= (r_fill < 6'(sha_pkg::LenBytePos));
                        r_full    <= (r_fill == 6'd63);
                        r_state   <= F_PAD;
                    end
                end
                F_PAD: begin
                    if (!r_full) begin
                        if (!i_eng_busy) begin
                            r_fill <= r_fill + 6'd1;
                            if (r_fill == 6'd63) r_full <= 1'b1;
                        end
                    end else if (!i_eng_busy && !r_padlast) begin
                        r_padlast <= 1'b1;
                    end
                end
                F_WAIT: begin
                    if (i_eng_done) begin
                        r_state <= F_DONE;
                    end
                end
                F_DONE: begin
                    // engine restores the chaining state in this cycle
                    r_state <= F_IDLE; r_len <= 64'd0; r_fill <= 6'd0;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule

>>> sv/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher.
//
//  channel  | dir | transfer payload
//  ---------+-----+------------------------------------------------
//  in_ch    | in  | data_byte[8], byte_present, end_of_message
//  out_ch   | out | digest_word[32], word_index[3], last_word
//
// Bytes are taken while the block buffer is filling. After the 64th byte
// of a block, input stalls through the hand-over, the request, the load,
// 64 rounds (one per cycle through the shared round unit) and the chaining
// add. An end transfer costs padding writes (one byte per cycle into the
// buffer memory, never while the engine reads it), one or two compressions
// and eight digest transfers, then a restore of the initial state. Reset
// is synchronous, active low; after it the engine loads the initial
// hash values. Output stalls hold the current digest word and keep
// input stalled.
module sha256_stream_hasher (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    sha_pkg::t_blk_req req;
    logic              eng_busy;
    logic [3:0]        rd_addr;
    sha_pkg::t_word    rd_word;
    logic              eng_done;

    // done once the final word is taken
    assign eng_done = out_ch.valid && out_ch.ready && out_ch.last_word;

    sha_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .o_req      (req),
        .i_eng_busy (eng_busy),
        .i_eng_done (eng_done),
        .i_rd_addr  (rd_addr),
        .o_rd_word  (rd_word)
    );

    sha_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .o_busy     (eng_busy),
        .o_blk_addr (rd_addr),
        .i_blk_word (rd_word),
        .o_valid    (out_ch.valid),
        .i_ready    (out_ch.ready),
        .o_word     (out_ch.digest_word),
        .o_index    (out_ch.word_index)
    );

    assign out_ch.last_word = (out_ch.word_index == 3'd7);
endmodule
